>>> hw/rtl/slit_pkg.sv
package slit_pkg;

  localparam int WaveW = 16;
  localparam int LevelW = 32;
  localparam int HeldW = 13;
  localparam int MagW = 49;
  localparam int StepW = 6;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_WINDOW = 2'd3;

  localparam logic CFG_LOW = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

  typedef struct packed {
    logic [WaveW-1:0] wave;
    logic signed [LevelW-1:0] level;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [MagW-1:0] dividend;
    logic [WaveW-1:0] divisor;
  } div_req_t;

endpackage

>>> hw/rtl/slit_mem.sv
module slit_mem #(
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  slit_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output slit_pkg::entry_t    rdata
);

  slit_pkg::entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/slit_div.sv
module slit_div (
  input  logic                               clk,
  input  logic                               rst,
  input  slit_pkg::div_req_t                 req,
  output logic                               done,
  output logic [slit_pkg::MagW-1:0]          quotient
);

  logic [slit_pkg::WaveW-1:0] divisor;
  logic [slit_pkg::WaveW-1:0] rem;
  logic [slit_pkg::StepW-1:0] steps;
  logic                       busy;
  logic [slit_pkg::WaveW:0]   rem_sh;
  logic [slit_pkg::WaveW:0]   rem_sub;

  assign rem_sh = {rem, quotient[slit_pkg::MagW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        steps <= '0;
        rem <= '0;
        divisor <= req.divisor;
        quotient <= req.dividend;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= rem_sub[slit_pkg::WaveW-1:0];
          quotient <= {quotient[slit_pkg::MagW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[slit_pkg::WaveW-1:0];
          quotient <= {quotient[slit_pkg::MagW-2:0], 1'b0};
        end
        steps <= steps + 1'b1;
        if (steps == slit_pkg::StepW'(slit_pkg::MagW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/spectrum_linear_interp_table.sv
// Wavelength/value table with piecewise linear lookup. A query scans the table
// memory one entry per cycle in load order, then, unless the hit is exact or the
// first entry, does one multiply and a 49-step serial divide. Loads outside
// [window_low, window_high] or into a full table are dropped and flagged in status.
module spectrum_linear_interp_table #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] wavelength,
  input  logic signed [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] result_value,
  output logic [1:0]  status,
  output logic [12:0] entries_held,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0]  state;
  logic [15:0] window_low;
  logic [15:0] window_high;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic        pend;
  logic        pend_first;
  logic [15:0] q;
  slit_pkg::entry_t prev;
  slit_pkg::entry_t hit_entry;
  logic signed [31:0] pr_val;
  logic [1:0]  pr_st;
  logic signed [49:0] prod;
  logic [15:0] dw;
  logic        neg;

  logic        accept;
  logic        load_ok;
  logic        rd_en;
  logic        hit;
  slit_pkg::entry_t rdata;
  slit_pkg::entry_t wdata;
  slit_pkg::div_req_t div_req;
  logic        div_done;
  logic [slit_pkg::MagW-1:0] div_q;
  logic signed [32:0] diff;
  logic signed [49:0] prod_next;
  logic signed [32:0] res_next;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign load_ok = !(wavelength < window_low || wavelength > window_high)
                   && (count != CW'(TABLE_DEPTH));
  assign wdata.wave = wavelength;
  assign wdata.level = sample_value;
  assign rd_en = (state == S_SCAN) && (idx < count) && !hit;
  assign hit = (state == S_SCAN) && pend && (rdata.wave >= q);

  assign diff = 33'(hit_entry.level) - 33'(prev.level);
  assign prod_next = 50'(diff) * $signed({34'd0, hit_entry.wave - q});
  assign div_req.start = (state == S_DIV);
  assign div_req.dividend = prod[49] ? 49'(-prod) : prod[48:0];
  assign div_req.divisor = dw;
  assign res_next = 33'(hit_entry.level) - (neg ? -33'(div_q) : 33'(div_q));

  slit_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (accept && action == slit_pkg::ACT_LOAD && load_ok),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  slit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low <= 16'd24320;
      window_high <= 16'd49920;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == slit_pkg::CFG_LOW) begin
        window_low <= cfg_data;
      end else begin
        window_high <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pr_val <= '0;
            pr_st <= slit_pkg::ST_OK;
            state <= S_FIN;
            case (action)
              slit_pkg::ACT_CLEAR: begin
                count <= '0;
              end
              slit_pkg::ACT_LOAD: begin
                if (wavelength < window_low || wavelength > window_high) begin
                  pr_st <= slit_pkg::ST_WINDOW;
                end else if (count == CW'(TABLE_DEPTH)) begin
                  pr_st <= slit_pkg::ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              slit_pkg::ACT_QUERY: begin
                q <= wavelength;
                idx <= '0;
                pend <= 1'b0;
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          pend <= rd_en;
          pend_first <= (idx == '0);
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          if (hit) begin
            hit_entry <= rdata;
            if (pend_first || rdata.wave == q) begin
              pr_val <= rdata.level;
              state <= S_FIN;
            end else begin
              state <= S_MUL;
            end
          end else begin
            if (pend) begin
              prev <= rdata;
            end
            if (!(idx < count)) begin
              pr_st <= slit_pkg::ST_NONE;
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          prod <= prod_next;
          dw <= hit_entry.wave - prev.wave;
          neg <= prod_next[49];
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            pr_val <= res_next[31:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            result_value <= pr_val;
            status <= pr_st;
            entries_held <= 13'(count);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/slit_checker.sv
module slit_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [31:0] result_value,
  input logic [1:0]  status,
  input logic [12:0] entries_held
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status)
      && $stable(entries_held))
    else $error("stalled output beat changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == slit_pkg::ST_NONE |-> result_value == 32'sd0)
    else $error("not-found beat carries a value");

  a_window_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == slit_pkg::ST_WINDOW || status == slit_pkg::ST_FULL)
      |-> result_value == 32'sd0)
    else $error("dropped load beat carries a value");

endmodule

bind spectrum_linear_interp_table slit_checker u_slit_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .status       (status),
  .entries_held (entries_held)
);
